FILE: rtl/core/sga_pkg.sv
package sga_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [15:0] THR_LOW_RESET    = 16'd1100;
  localparam logic [15:0] ARM_RUD_RESET    = 16'd1900;
  localparam logic [15:0] DISARM_RUD_RESET = 16'd1100;
  localparam logic [31:0] HOLD_MS_RESET    = 32'd1000;

  typedef enum logic [2:0] {
    MODE_STANDBY  = 3'd0,
    MODE_FAILSAFE = 3'd1,
    MODE_BLOCKED  = 3'd2,
    MODE_READY    = 3'd3,
    MODE_ARMED    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    WHY_INIT     = 3'd0,
    WHY_FAILSAFE = 3'd1,
    WHY_PASSED   = 3'd2,
    WHY_BLOCKED  = 3'd3,
    WHY_READY    = 3'd4,
    WHY_ARMED    = 3'd5,
    WHY_DISARMED = 3'd6
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR_LOW    = 3'd0,
    CFG_ARM_RUD    = 3'd1,
    CFG_DISARM_RUD = 3'd2,
    CFG_HOLD_MS    = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] throttle_low_limit;
    logic [15:0] arm_rud_floor;
    logic [15:0] disarm_rud_ceil;
    logic [31:0] hold_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [15:0] throttle_value;
    logic [15:0] rudder_value;
    logic        failsafe_active;
    logic        preflight_ok;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    mode_t   mode;
    reason_t reason;
    logic    arm_timing;
    logic    disarm_timing;
  } sga_ctl_t;

  function automatic sga_ctl_t go_to(mode_t m, reason_t r);
    sga_ctl_t c;
    c.mode          = m;
    c.reason        = r;
    c.arm_timing    = 1'b0;
    c.disarm_timing = 1'b0;
    return c;
  endfunction

endpackage

FILE: rtl/core/sga_in_if.sv
interface sga_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] throttle_value;
  logic [15:0] rudder_value;
  logic        failsafe_active;
  logic        preflight_ok;
  logic [31:0] now_ms;

  modport source (
    output valid, throttle_value, rudder_value, failsafe_active, preflight_ok, now_ms,
    input  ready
  );
  modport sink (
    input  valid, throttle_value, rudder_value, failsafe_active, preflight_ok, now_ms,
    output ready
  );
endinterface

FILE: rtl/core/sga_out_if.sv
interface sga_out_if;
  logic            valid;
  logic            ready;
  sga_pkg::mode_t   mode;
  sga_pkg::reason_t reason_code;

  modport source (output valid, mode, reason_code, input ready);
  modport sink (input valid, mode, reason_code, output ready);
endinterface

FILE: rtl/core/sga_cfg_if.sv
interface sga_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sga_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sga_cfg_regs.sv
module sga_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [sga_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]   wr_data,
  output sga_pkg::cfg_t cfg
);
  import sga_pkg::*;

  cfg_t cfg_r;

  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_low_limit <= THR_LOW_RESET;
      cfg_r.arm_rud_floor      <= ARM_RUD_RESET;
      cfg_r.disarm_rud_ceil    <= DISARM_RUD_RESET;
      cfg_r.hold_time_ms       <= HOLD_MS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_THR_LOW:    cfg_r.throttle_low_limit <= wr_data[15:0];
        CFG_ARM_RUD:    cfg_r.arm_rud_floor      <= wr_data[15:0];
        CFG_DISARM_RUD: cfg_r.disarm_rud_ceil    <= wr_data[15:0];
        CFG_HOLD_MS:    cfg_r.hold_time_ms       <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/sga_step.sv
module sga_step #(
  parameter int TIME_BITS = 32
) (
  input  sga_pkg::sga_ctl_t ctl,
  input  logic [TIME_BITS-1:0] arm_start,
  input  logic [TIME_BITS-1:0] disarm_start,
  input  sga_pkg::in_item_t item,
  input  sga_pkg::cfg_t     cfg,
  output sga_pkg::sga_ctl_t ctl_nxt,
  output logic [TIME_BITS-1:0] arm_start_nxt,
  output logic [TIME_BITS-1:0] disarm_start_nxt
);
  import sga_pkg::*;

  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [CMP_W-1:0]     now_ext;
  logic [TIME_BITS-1:0] now_t;
  logic                 arm_run;
  logic [TIME_BITS-1:0] arm_base;
  logic [TIME_BITS-1:0] disarm_base;
  logic [TIME_BITS-1:0] arm_el;
  logic [TIME_BITS-1:0] disarm_el;
  logic                 low_thr;
  logic                 arm_gest;
  logic                 disarm_gest;
  logic                 arm_done;
  logic                 disarm_done;

  assign now_ext = CMP_W'(item.now_ms);
  assign now_t   = now_ext[TIME_BITS-1:0];

  // arm timer survives only if we were already in ready-to-arm
  assign arm_run     = ctl.arm_timing && (ctl.mode == MODE_READY);
  assign arm_base    = arm_run ? arm_start : now_t;
  assign disarm_base = ctl.disarm_timing ? disarm_start : now_t;
  assign arm_el      = now_t - arm_base;
  assign disarm_el   = now_t - disarm_base;

  assign low_thr     = item.throttle_value < cfg.throttle_low_limit;
  assign arm_gest    = low_thr && (item.rudder_value >= cfg.arm_rud_floor);
  assign disarm_gest = low_thr && (item.rudder_value <= cfg.disarm_rud_ceil);
  assign arm_done    = CMP_W'(arm_el) >= CMP_W'(cfg.hold_time_ms);
  assign disarm_done = CMP_W'(disarm_el) >= CMP_W'(cfg.hold_time_ms);

  always_comb begin
    ctl_nxt          = ctl;
    arm_start_nxt    = arm_start;
    disarm_start_nxt = disarm_start;
    if (item.failsafe_active) begin
      ctl_nxt = go_to(MODE_FAILSAFE, WHY_FAILSAFE);
    end else if (ctl.mode != MODE_ARMED) begin
      if (!item.preflight_ok) begin
        if (ctl.mode != MODE_BLOCKED) begin
          ctl_nxt = go_to(MODE_BLOCKED, WHY_BLOCKED);
        end
      end else begin
        if (ctl.mode == MODE_FAILSAFE || ctl.mode == MODE_STANDBY) begin
          ctl_nxt = go_to(MODE_READY, WHY_PASSED);
        end else if (ctl.mode != MODE_READY) begin
          ctl_nxt = go_to(MODE_READY, WHY_READY);
        end
        if (arm_gest) begin
          if (arm_done) begin
            ctl_nxt = go_to(MODE_ARMED, WHY_ARMED);
          end else begin
            ctl_nxt.arm_timing = 1'b1;
            arm_start_nxt      = arm_base;
          end
        end else begin
          ctl_nxt.arm_timing = 1'b0;
        end
      end
    end else begin
      if (disarm_gest) begin
        if (disarm_done) begin
          ctl_nxt = go_to(MODE_READY, WHY_DISARMED);
        end else begin
          ctl_nxt.disarm_timing = 1'b1;
          disarm_start_nxt      = disarm_base;
        end
      end else begin
        ctl_nxt.disarm_timing = 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/stick_gesture_arming_fsm_core.sv
// Stick-gesture arming state machine.
// in_if  : one control update per transfer (throttle, rudder, failsafe,
//          preflight, millisecond timestamp).
// out_if : one result per update, the flight mode and the reason code of
//          the last mode change.
// cfg_if : register writes (index, data); always ready. Write only while
//          no update is in flight.
// Pipeline: an accepted update is registered in the input register, its
//          result is registered in the output register and offered from then on.
// Throughput: one update per cycle while out_if.ready is high; the mode/timer
//          state register closes its loop through the next-state logic.
// Reset: mode standby, reason init, both hold timers stopped, registers
//          at their defaults, both channels empty.
// Stall: while out_if.ready is low the result holds; the input register
//          still takes one more update, then in_if.ready drops.
module stick_gesture_arming_fsm_core #(
  parameter int TIME_BITS = 32
) (
  input logic clk,
  input logic rst_n,
  sga_in_if.sink    in_if,
  sga_out_if.source out_if,
  sga_cfg_if.sink   cfg_if
);
  import sga_pkg::*;

  logic                 in_vld_r;
  in_item_t             in_item_r;
  logic                 out_vld_r;
  mode_t                out_mode_r;
  reason_t              out_reason_r;
  logic                 advance;
  cfg_t                 cfg;
  sga_ctl_t             ctl_r;
  sga_ctl_t             ctl_nxt;
  logic [TIME_BITS-1:0] arm_start_r;
  logic [TIME_BITS-1:0] arm_start_nxt;
  logic [TIME_BITS-1:0] disarm_start_r;
  logic [TIME_BITS-1:0] disarm_start_nxt;

  assign cfg_if.ready = 1'b1;

  sga_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_if.valid && cfg_if.ready),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg)
  );

  assign advance     = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_item_r.throttle_value  <= in_if.throttle_value;
      in_item_r.rudder_value    <= in_if.rudder_value;
      in_item_r.failsafe_active <= in_if.failsafe_active;
      in_item_r.preflight_ok    <= in_if.preflight_ok;
      in_item_r.now_ms          <= in_if.now_ms;
    end
  end

  sga_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .ctl              (ctl_r),
    .arm_start        (arm_start_r),
    .disarm_start     (disarm_start_r),
    .item             (in_item_r),
    .cfg              (cfg),
    .ctl_nxt          (ctl_nxt),
    .arm_start_nxt    (arm_start_nxt),
    .disarm_start_nxt (disarm_start_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= go_to(MODE_STANDBY, WHY_INIT);
    end else if (advance) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      arm_start_r    <= arm_start_nxt;
      disarm_start_r <= disarm_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode_r   <= ctl_nxt.mode;
      out_reason_r <= ctl_nxt.reason;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.mode        = out_mode_r;
  assign out_if.reason_code = out_reason_r;

endmodule

FILE: rtl/core/sga_checker.sv
module sga_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input sga_pkg::mode_t   out_mode,
  input sga_pkg::reason_t out_reason
);
  import sga_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mode) && $stable(out_reason))
    else $error("result changed while stalled");

  a_armed_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode == MODE_ARMED) |-> (out_reason == WHY_ARMED))
    else $error("armed without arm gesture reason");

  a_failsafe_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode == MODE_FAILSAFE) |-> (out_reason == WHY_FAILSAFE))
    else $error("failsafe mode with wrong reason");

  a_blocked_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode == MODE_BLOCKED) |-> (out_reason == WHY_BLOCKED))
    else $error("blocked mode with wrong reason");

endmodule

bind stick_gesture_arming_fsm_core sga_checker u_sga_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_mode   (out_if.mode),
  .out_reason (out_if.reason_code)
);

FILE: tb/tb_stick_gesture_arming_fsm_core.sv
module tb_stick_gesture_arming_fsm_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sga_pkg::*;

  localparam int CFG_FIRST_UNUSED = int'(CFG_HOLD_MS) + 1;
  localparam int CFG_SLOTS        = 1 << CFG_IDX_W;
  localparam int PHASES           = 7;
  localparam int PHASE_ITEMS      = 107;
  localparam int IDLE_PCT         = 37;

  typedef struct {
    mode_t   mode;
    reason_t why;
  } mode_pair_t;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
    in_item_t             upd;
    bit                   fixed;
    mode_t                mode;
    reason_t              why;
  } plan_row_t;

  logic clk;
  logic rst_n;

  sga_in_if  in_ch ();
  sga_out_if out_ch ();
  sga_cfg_if cfg_ch ();

  stick_gesture_arming_fsm_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  mode_t       fsm_mode;
  reason_t     fsm_why;
  logic [31:0] arm_since;
  logic [31:0] disarm_since;
  bit          arm_run;
  bit          disarm_run;
  logic [15:0] lim_thr;
  logic [15:0] lim_arm;
  logic [15:0] lim_disarm;
  logic [31:0] lim_hold;

  mode_pair_t  pending_modes[$];
  mode_pair_t  head_pair;
  in_item_t    seen_upd;
  plan_row_t   plan_q[$];

  bit          fixed_on;
  mode_t       fixed_mode;
  reason_t     fixed_why;
  bit          calm;

  int n_errors;
  int n_updates;
  int n_checked;
  int n_writes;
  int n_arms;
  int n_disarms;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** stick_gesture_arming_fsm_core: FAILED **");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  function automatic void enter_mode(mode_t m, reason_t r);
    fsm_mode     = m;
    fsm_why      = r;
    arm_since    = '0;
    arm_run      = 1'b0;
    disarm_since = '0;
    disarm_run   = 1'b0;
  endfunction

  function automatic bit held_long(inout logic [31:0] since, inout bit run,
                                   input logic [31:0] now);
    logic [31:0] gone;
    if (!run) begin
      since = now;
      run   = 1'b1;
    end
    gone = now - since;
    return gone >= lim_hold;
  endfunction

  function automatic void advance_arming(in_item_t u);
    bit low_thr;
    low_thr = u.throttle_value < lim_thr;
    if (u.failsafe_active) begin
      enter_mode(MODE_FAILSAFE, WHY_FAILSAFE);
      return;
    end
    if (fsm_mode == MODE_FAILSAFE || fsm_mode == MODE_STANDBY) begin
      if (u.preflight_ok) enter_mode(MODE_READY, WHY_PASSED);
      else enter_mode(MODE_BLOCKED, WHY_BLOCKED);
    end
    if (fsm_mode != MODE_ARMED) begin
      if (!u.preflight_ok) begin
        if (fsm_mode != MODE_BLOCKED) enter_mode(MODE_BLOCKED, WHY_BLOCKED);
        return;
      end
      if (fsm_mode != MODE_READY) enter_mode(MODE_READY, WHY_READY);
      if (low_thr && u.rudder_value >= lim_arm) begin
        if (held_long(arm_since, arm_run, u.now_ms)) begin
          enter_mode(MODE_ARMED, WHY_ARMED);
          n_arms++;
        end
      end else begin
        arm_since = '0;
        arm_run   = 1'b0;
      end
    end else begin
      if (low_thr && u.rudder_value <= lim_disarm) begin
        if (held_long(disarm_since, disarm_run, u.now_ms)) begin
          enter_mode(MODE_READY, WHY_DISARMED);
          n_disarms++;
        end
      end else begin
        disarm_since = '0;
        disarm_run   = 1'b0;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        n_writes++;
        case (cfg_ch.index)
          CFG_THR_LOW:    lim_thr    = cfg_ch.data[15:0];
          CFG_ARM_RUD:    lim_arm    = cfg_ch.data[15:0];
          CFG_DISARM_RUD: lim_disarm = cfg_ch.data[15:0];
          CFG_HOLD_MS:    lim_hold   = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_modes.size() == 0) begin
          report_mismatch($sformatf("result mode %0d reason %0d with no update pending",
                                    out_ch.mode, out_ch.reason_code));
        end else begin
          head_pair = pending_modes.pop_front();
          n_checked++;
          if (out_ch.mode !== head_pair.mode)
            report_mismatch($sformatf("result %0d: mode %0d, expected %0d",
                                      n_checked, out_ch.mode, head_pair.mode));
          if (out_ch.reason_code !== head_pair.why)
            report_mismatch($sformatf("result %0d: reason %0d, expected %0d",
                                      n_checked, out_ch.reason_code, head_pair.why));
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        seen_upd.throttle_value  = in_ch.throttle_value;
        seen_upd.rudder_value    = in_ch.rudder_value;
        seen_upd.failsafe_active = in_ch.failsafe_active;
        seen_upd.preflight_ok    = in_ch.preflight_ok;
        seen_upd.now_ms          = in_ch.now_ms;
        advance_arming(seen_upd);
        n_updates++;
        if (fixed_on) pending_modes.push_back('{fixed_mode, fixed_why});
        else pending_modes.push_back('{fsm_mode, fsm_why});
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic send_update(in_item_t u, bit fix, mode_t fm, reason_t fr);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.throttle_value  <= u.throttle_value;
    in_ch.rudder_value    <= u.rudder_value;
    in_ch.failsafe_active <= u.failsafe_active;
    in_ch.preflight_ok    <= u.preflight_ok;
    in_ch.now_ms          <= u.now_ms;
    fixed_on              <= fix;
    fixed_mode            <= fm;
    fixed_why             <= fr;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_modes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void add_update(logic [15:0] thr, logic [15:0] rud, bit fs, bit pre,
                                     logic [31:0] now, bit fix = 1'b0,
                                     mode_t m = MODE_STANDBY, reason_t r = WHY_INIT);
    plan_row_t row;
    row.is_write            = 1'b0;
    row.idx                 = '0;
    row.data                = '0;
    row.upd.throttle_value  = thr;
    row.upd.rudder_value    = rud;
    row.upd.failsafe_active = fs;
    row.upd.preflight_ok    = pre;
    row.upd.now_ms          = now;
    row.fixed               = fix;
    row.mode                = m;
    row.why                 = r;
    plan_q.push_back(row);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    plan_row_t row;
    row.upd      = '0;
    row.fixed    = 1'b0;
    row.is_write = 1'b1;
    row.idx      = idx;
    row.data     = data;
    row.mode     = MODE_STANDBY;
    row.why      = WHY_INIT;
    plan_q.push_back(row);
  endfunction

  function automatic logic [15:0] pick_low_thr();
    if (lim_thr == 0) return '0;
    if ($urandom_range(0, 3) == 0) return lim_thr - 16'd1;
    return 16'($urandom_range(0, lim_thr - 1));
  endfunction

  function automatic logic [15:0] pick_arm_rud();
    if ($urandom_range(0, 3) == 0) return lim_arm;
    return 16'($urandom_range(lim_arm, 16'hFFFF));
  endfunction

  function automatic logic [15:0] pick_disarm_rud();
    if ($urandom_range(0, 3) == 0) return lim_disarm;
    return 16'($urandom_range(0, lim_disarm));
  endfunction

  initial begin
    int          kind;
    int          seg_len;
    int          left;
    int          max_step;
    logic [31:0] clock_ms;
    in_item_t    u;

    rst_n                 = 1'b0;
    calm                  = 1'b0;
    fixed_on              = 1'b0;
    fixed_mode            = MODE_STANDBY;
    fixed_why             = WHY_INIT;
    in_ch.valid           = 1'b0;
    in_ch.throttle_value  = '0;
    in_ch.rudder_value    = '0;
    in_ch.failsafe_active = 1'b0;
    in_ch.preflight_ok    = 1'b0;
    in_ch.now_ms          = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    lim_thr               = THR_LOW_RESET;
    lim_arm               = ARM_RUD_RESET;
    lim_disarm            = DISARM_RUD_RESET;
    lim_hold              = HOLD_MS_RESET;
    enter_mode(MODE_STANDBY, WHY_INIT);

    add_update(16'd0, 16'd0, 1'b1, 1'b0, 32'd0, 1'b1, MODE_FAILSAFE, WHY_FAILSAFE);
    add_update(16'd0, 16'd0, 1'b0, 1'b0, 32'd0, 1'b1, MODE_BLOCKED, WHY_BLOCKED);
    add_update(16'd1500, 16'd1500, 1'b0, 1'b1, 32'd10, 1'b1, MODE_READY, WHY_READY);
    add_update(16'd0, 16'hFFFF, 1'b0, 1'b1, 32'd0);
    add_update(16'd1099, 16'd1900, 1'b0, 1'b1, 32'd999);
    add_update(16'd1099, 16'd1900, 1'b0, 1'b1, 32'd1000);
    add_update(16'd0, 16'd0, 1'b0, 1'b1, 32'hFFFF_FE00);
    add_update(16'd0, 16'd0, 1'b0, 1'b1, 32'h0000_01E8);
    add_update(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, MODE_FAILSAFE,
               WHY_FAILSAFE);
    add_update(16'hFFFF, 16'd0, 1'b0, 1'b1, 32'd50, 1'b1, MODE_READY, WHY_PASSED);
    add_update(16'd0, 16'hFFFF, 1'b0, 1'b1, 32'd100);
    add_update(16'd1100, 16'hFFFF, 1'b0, 1'b1, 32'd200);
    add_update(16'd0, 16'hFFFF, 1'b0, 1'b1, 32'd1200);
    add_update(16'd0, 16'hFFFF, 1'b0, 1'b1, 32'd2200);
    add_update(16'd5000, 16'd5000, 1'b0, 1'b0, 32'd2300);
    add_update(16'd1099, 16'd1100, 1'b0, 1'b0, 32'd3000);
    add_update(16'd1099, 16'd1100, 1'b0, 1'b0, 32'd3999);
    add_update(16'd0, 16'd0, 1'b1, 1'b1, 32'd4000, 1'b1, MODE_FAILSAFE, WHY_FAILSAFE);
    add_update(16'd0, 16'd0, 1'b0, 1'b0, 32'd4001, 1'b1, MODE_BLOCKED, WHY_BLOCKED);
    add_write(CFG_HOLD_MS, 32'd0);
    add_write(CFG_IDX_W'(CFG_FIRST_UNUSED + 1), 32'hFFFF_FFFF);
    add_update(16'd0, 16'd1900, 1'b0, 1'b1, 32'd7);
    add_update(16'd0, 16'd1100, 1'b0, 1'b1, 32'd7);
    add_write(CFG_HOLD_MS, 32'hFFFF_FFFF);
    add_update(16'd0, 16'd2000, 1'b0, 1'b1, 32'd5);
    add_update(16'd0, 16'd2000, 1'b0, 1'b1, 32'd4);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_write) begin
        drain_results();
        write_reg(plan_q[i].idx, plan_q[i].data);
      end else begin
        send_update(plan_q[i].upd, plan_q[i].fixed, plan_q[i].mode, plan_q[i].why);
      end
    end

    clock_ms = $urandom();
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(CFG_THR_LOW, 32'd1100);
          write_reg(CFG_ARM_RUD, 32'd1900);
          write_reg(CFG_DISARM_RUD, 32'd1100);
          write_reg(CFG_HOLD_MS, 32'd1000);
          max_step = 300;
        end
        1: begin
          write_reg(CFG_THR_LOW, 32'hFFFF);
          write_reg(CFG_ARM_RUD, 32'd0);
          write_reg(CFG_DISARM_RUD, 32'hFFFF);
          write_reg(CFG_HOLD_MS, 32'd0);
          max_step = 3;
        end
        2: begin
          write_reg(CFG_THR_LOW, 32'd0);
          write_reg(CFG_ARM_RUD, 32'hFFFF);
          write_reg(CFG_DISARM_RUD, 32'd0);
          write_reg(CFG_HOLD_MS, 32'd5);
          max_step = 4;
        end
        3: begin
          write_reg(CFG_THR_LOW, $urandom_range(500, 3000));
          write_reg(CFG_ARM_RUD, $urandom_range(0, 16'hFFFF));
          write_reg(CFG_DISARM_RUD, $urandom_range(0, 16'hFFFF));
          write_reg(CFG_HOLD_MS, $urandom_range(0, 40));
          max_step = 12;
        end
        4: begin
          write_reg(CFG_THR_LOW, 32'd2000);
          write_reg(CFG_ARM_RUD, 32'd1500);
          write_reg(CFG_DISARM_RUD, 32'd1500);
          write_reg(CFG_HOLD_MS, 32'hFFFF_FFF0);
          max_step = 6;
        end
        5: begin
          write_reg(CFG_THR_LOW, 32'd1100);
          write_reg(CFG_ARM_RUD, 32'd1900);
          write_reg(CFG_DISARM_RUD, 32'd1100);
          write_reg(CFG_HOLD_MS, 32'hFFFF_FFFF);
          max_step = 500;
        end
        default: begin
          write_reg(CFG_THR_LOW, $urandom());
          write_reg(CFG_ARM_RUD, $urandom());
          write_reg(CFG_DISARM_RUD, $urandom());
          write_reg(CFG_HOLD_MS, $urandom_range(1, 2000));
          max_step = 400;
        end
      endcase
      write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_SLOTS - 1)), $urandom());
      calm = (ph == 3);

      left = PHASE_ITEMS;
      while (left > 0) begin
        kind    = $urandom_range(0, 99);
        seg_len = $urandom_range(1, 12);
        for (int k = 0; k < seg_len && left > 0; k++) begin
          if ($urandom_range(0, 7) == 0) clock_ms -= $urandom_range(1, 32);
          else clock_ms += $urandom_range(0, max_step);
          u.now_ms          = clock_ms;
          u.failsafe_active = ($urandom_range(0, 99) < 2);
          u.preflight_ok    = ($urandom_range(0, 99) < 92);
          if (kind < 45) begin
            u.throttle_value = pick_low_thr();
            u.rudder_value   = pick_arm_rud();
          end else if (kind < 75) begin
            u.throttle_value = pick_low_thr();
            u.rudder_value   = pick_disarm_rud();
          end else if (kind < 85) begin
            u.throttle_value = 16'($urandom_range(lim_thr, 16'hFFFF));
            u.rudder_value   = 16'($urandom());
          end else if (kind < 93) begin
            u.throttle_value  = 16'($urandom());
            u.rudder_value    = 16'($urandom());
            u.failsafe_active = 1'($urandom_range(0, 1));
            u.preflight_ok    = 1'($urandom_range(0, 1));
            u.now_ms          = $urandom();
          end else begin
            u.throttle_value  = 16'($urandom());
            u.rudder_value    = 16'($urandom());
            u.failsafe_active = 1'($urandom_range(0, 1));
          end
          send_update(u, 1'b0, MODE_STANDBY, WHY_INIT);
          left--;
          if (ph == 2 && left == PHASE_ITEMS / 2) drain_results();
        end
      end
    end

    calm = 1'b0;
    drain_results();
    repeat (4) @(posedge clk);

    $display("run: %0d updates, %0d results checked, %0d register writes over %0d phases",
             n_updates, n_checked, n_writes, PHASES);
    $display("run: %0d arm and %0d disarm events, %0d results still pending",
             n_arms, n_disarms, pending_modes.size());
    if (n_errors == 0 && pending_modes.size() == 0) begin
      $display("** stick_gesture_arming_fsm_core: PASSED **");
    end else begin
      $display("** stick_gesture_arming_fsm_core: FAILED **");
    end
    $finish;
  end

endmodule
